@@ rtl/core/glos_pkg.sv @@
// Types and constants shared by the grid line-of-sight core.
`timescale 1ns / 1ps

package glos_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_BLOCK = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_SIGHT = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_HEIGHT = 1'b0;
    localparam logic CFG_WIDTH  = 1'b1;

    // Width of the signed walk decision; the six-bit coordinates bound it
    // well below 2**13.
    localparam int D_W = 15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_WALK,
        ST_FINISH
    } glos_state_t;

endpackage

@@ rtl/core/grid_line_of_sight_core.sv @@
// Occupancy grid with a line-of-sight query walked out over a row memory.
// A cell write reads its row, merges the cell in ST_WRITE and answers from ST_FINISH;
// a query steps cell by cell through ST_WALK and then answers from ST_FINISH.
// Throughput: one item at a time, set by the one-row-per-cycle memory read of the walk.
// Reset: the grid registers return to 64 (clamped to the maximum), and a
// clearing pass frees every cell, row by row, before the first transfer.
`timescale 1ns / 1ps

module grid_line_of_sight_core
    import glos_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [5:0] row_a,
    input  logic [5:0] col_a,
    input  logic [5:0] row_b,
    input  logic [5:0] col_b,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       visible,
    output logic       status,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam logic [6:0] H_RST = 7'((MAX_ROWS < 64) ? MAX_ROWS : 64);
    localparam logic [6:0] W_RST = 7'((MAX_COLS < 64) ? MAX_COLS : 64);

    // The occupancy memory holds one row of cells per entry, 1 meaning blocked.
    // It has one write port and one registered read port.
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rdata_reg;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Configuration. A value below 3 acts as 3 and one above the maximum
    // acts as the maximum.
    logic [6:0] h_reg;
    logic [6:0] w_reg;
    logic [6:0] cfg_h_clamped;
    logic [6:0] cfg_w_clamped;

    always_comb
    begin
        cfg_h_clamped = cfg_data;
        if (cfg_data < 7'd3)
        begin
            cfg_h_clamped = 7'd3;
        end
        else if (int'(cfg_data) > MAX_ROWS)
        begin
            cfg_h_clamped = 7'(MAX_ROWS);
        end
        cfg_w_clamped = cfg_data;
        if (cfg_data < 7'd3)
        begin
            cfg_w_clamped = 7'd3;
        end
        else if (int'(cfg_data) > MAX_COLS)
        begin
            cfg_w_clamped = 7'(MAX_COLS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= H_RST;
            w_reg <= W_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HEIGHT)
            begin
                h_reg <= cfg_h_clamped;
            end
            else
            begin
                w_reg <= cfg_w_clamped;
            end
        end
    end

    // Control and walk state.
    glos_state_t           state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [5:0]            r_reg, r_next;
    logic [5:0]            c_reg, c_next;
    logic                  r_dec_reg, r_dec_next;
    logic                  c_dec_reg, c_dec_next;
    logic [5:0]            dr_reg, dr_next;
    logic [5:0]            dc_reg, dc_next;
    logic [5:0]            ix_reg, ix_next;
    logic [5:0]            iy_reg, iy_next;
    logic signed [D_W-1:0] d_reg, d_next;
    logic                  wblk_reg, wblk_next;
    logic                  pend_reg, pend_next;
    logic                  pend_wall_reg, pend_wall_next;
    logic [CW-1:0]         pend_col_reg, pend_col_next;
    logic                  res_vis_reg, res_vis_next;
    logic                  res_st_reg, res_st_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  visible_reg, visible_next;
    logic                  status_reg, status_next;

    // Helper terms of the combinational block.
    logic                  a_in_grid;
    logic                  b_in_grid;
    logic                  more;
    logic                  blocked_now;
    logic                  out_free;
    logic signed [D_W-1:0] dr2;
    logic signed [D_W-1:0] dc2;
    logic [5:0]            nr;
    logic [5:0]            nc;
    logic [5:0]            step_r;
    logic [5:0]            step_c;

    assign a_in_grid = ({1'b0, row_a} < h_reg) && ({1'b0, col_a} < w_reg);
    assign b_in_grid = ({1'b0, row_b} < h_reg) && ({1'b0, col_b} < w_reg);
    assign more      = (ix_reg != dr_reg) || (iy_reg != dc_reg);
    assign blocked_now = pend_reg && (pend_wall_reg || rdata_reg[pend_col_reg]);
    assign out_free  = !out_valid_reg || !out_stall;
    assign dr2       = $signed({{(D_W-7){1'b0}}, dr_reg, 1'b0});
    assign dc2       = $signed({{(D_W-7){1'b0}}, dc_reg, 1'b0});
    assign step_r    = r_dec_reg ? (r_reg - 6'd1) : (r_reg + 6'd1);
    assign step_c    = c_dec_reg ? (c_reg - 6'd1) : (c_reg + 6'd1);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        r_dec_next     = r_dec_reg;
        c_dec_next     = c_dec_reg;
        dr_next        = dr_reg;
        dc_next        = dc_reg;
        ix_next        = ix_reg;
        iy_next        = iy_reg;
        d_next         = d_reg;
        wblk_next      = wblk_reg;
        pend_next      = pend_reg;
        pend_wall_next = pend_wall_reg;
        pend_col_next  = pend_col_reg;
        res_vis_next   = res_vis_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        visible_next   = visible_reg;
        status_next    = status_reg;
        in_stall       = 1'b1;
        mem_re         = 1'b0;
        mem_raddr      = AW'(r_reg);
        mem_we         = 1'b0;
        mem_waddr      = AW'(r_reg);
        mem_wdata      = rdata_reg;
        nr             = r_reg;
        nc             = c_reg;

        // A waiting result leaves when the far side takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Free one row per cycle after reset.
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    r_next       = row_a;
                    c_next       = col_a;
                    res_vis_next = 1'b0;
                    res_st_next  = 1'b0;
                    unique case (opcode) inside
                        OP_BLOCK, OP_FREE:
                        begin
                            if (a_in_grid)
                            begin
                                // Read the row now, merge the cell next cycle.
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(row_a);
                                wblk_next  = (opcode == OP_BLOCK);
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                res_st_next = 1'b1;
                                state_next  = ST_FINISH;
                            end
                        end
                        OP_SIGHT:
                        begin
                            if (a_in_grid && b_in_grid)
                            begin
                                r_dec_next = (row_b < row_a);
                                c_dec_next = (col_b < col_a);
                                dr_next    = (row_b < row_a) ? (row_a - row_b) : (row_b - row_a);
                                dc_next    = (col_b < col_a) ? (col_a - col_b) : (col_b - col_a);
                                ix_next    = '0;
                                iy_next    = '0;
                                d_next     = $signed({{(D_W-6){1'b0}}, dr_next})
                                           - $signed({{(D_W-6){1'b0}}, dc_next});
                                pend_next  = 1'b0;
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                res_st_next = 1'b1;
                                state_next  = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            // The unused opcode is answered and otherwise ignored.
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_reg);
                mem_wdata = rdata_reg;
                mem_wdata[CW'(c_reg)] = wblk_reg;
                state_next = ST_FINISH;
            end
            ST_WALK:
            begin
                // Each cycle checks the cell read last cycle and, in parallel,
                // steps to the next cell and reads its row.
                if (blocked_now)
                begin
                    pend_next    = 1'b0;
                    res_vis_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else if (more)
                begin
                    if (d_reg == '0)
                    begin
                        nr      = step_r;
                        nc      = step_c;
                        ix_next = ix_reg + 6'd1;
                        iy_next = iy_reg + 6'd1;
                        d_next  = d_reg + dr2 - dc2;
                    end
                    else if (d_reg < 0)
                    begin
                        nc      = step_c;
                        iy_next = iy_reg + 6'd1;
                        d_next  = d_reg + dr2;
                    end
                    else
                    begin
                        nr      = step_r;
                        ix_next = ix_reg + 6'd1;
                        d_next  = d_reg - dc2;
                    end
                    r_next         = nr;
                    c_next         = nc;
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(nr);
                    pend_next      = 1'b1;
                    pend_col_next  = CW'(nc);
                    pend_wall_next = (nr == 6'd0) || (nc == 6'd0)
                                  || ({1'b0, nr} == h_reg - 7'd1)
                                  || ({1'b0, nc} == w_reg - 7'd1);
                end
                else
                begin
                    // Every cell up to and including the destination is free.
                    pend_next    = 1'b0;
                    res_vis_next = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    visible_next   = res_vis_reg;
                    status_next    = res_st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        c_reg         <= c_next;
        r_dec_reg     <= r_dec_next;
        c_dec_reg     <= c_dec_next;
        dr_reg        <= dr_next;
        dc_reg        <= dc_next;
        ix_reg        <= ix_next;
        iy_reg        <= iy_next;
        d_reg         <= d_next;
        wblk_reg      <= wblk_next;
        pend_wall_reg <= pend_wall_next;
        pend_col_reg  <= pend_col_next;
        res_vis_reg   <= res_vis_next;
        res_st_reg    <= res_st_next;
        visible_reg   <= visible_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign status    = status_reg;

    // A new result appears only when the finishing state hands it over.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finishing state");

    // The walk only reads the grid; nothing may write it mid-query.
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !mem_we)
        else $error("grid written during a sight walk");

    // The step counters stay inside the box spanned by the two endpoints.
    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (ix_reg <= dr_reg) && (iy_reg <= dc_reg))
        else $error("sight walk left the endpoint box");

    // No transfer is taken while the clearing pass runs.
    a_stall_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("input taken during the clearing pass");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the grid line-of-sight core.
`timescale 1ns / 1ps

module tb;
    import glos_pkg::*;

    // The core decodes opcode 3 as a no-op; it has no name in the package.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int GRID_MAX_ROWS = 64;
    localparam int GRID_MAX_COLS = 64;

    // Cycles with no transfer on either channel before the run is declared hung.
    // The slowest legal quiet stretch is the long output hold-off plus one
    // full-length walk, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 4000;

    // One answer from the core, in the order of its output fields.
    typedef struct packed {
        logic visible;
        logic status;
    } sight_answer_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] opcode;
    logic [5:0] row_a;
    logic [5:0] col_a;
    logic [5:0] row_b;
    logic [5:0] col_b;
    logic       out_valid;
    logic       out_stall;
    logic       visible;
    logic       status;
    logic       cfg_we;
    logic       cfg_index;
    logic [6:0] cfg_data;

    grid_line_of_sight_core #(
        .MAX_ROWS (GRID_MAX_ROWS),
        .MAX_COLS (GRID_MAX_COLS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .row_a     (row_a),
        .col_a     (col_a),
        .row_b     (row_b),
        .col_b     (col_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .visible   (visible),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns period, low half first.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the grid. Every cell bit is kept regardless of the
    // current size; the border is applied only when a cell is looked at,
    // exactly as the core does, so resizing never loses stored bits.
    // ------------------------------------------------------------------
    bit occ_map [GRID_MAX_ROWS][GRID_MAX_COLS];
    int rows_used = GRID_MAX_ROWS;
    int cols_used = GRID_MAX_COLS;

    // Answers still owed by the core, oldest first.
    sight_answer_t pending_answers [$];

    int errors          = 0;
    int items_sent      = 0;
    int queries_sent    = 0;
    int answers_checked = 0;
    int clear_seen      = 0;
    int rejects_seen    = 0;

    // Sender and receiver pacing knobs, changed by the test tasks.
    bit sender_gaps   = 1'b1;
    bit receiver_idle = 1'b1;
    int burst_left    = 0;
    int hold_left     = 0;
    int rx_mode_left  = 0;
    int rx_pct        = 0;
    int quiet_cycles  = 0;

    // Register values outside 3..max behave as the nearest limit.
    function automatic int clamp_size(input logic [6:0] value, input int top);
        int x;
        x = int'(value);
        if (x < 3)
            x = 3;
        if (x > top)
            x = top;
        return x;
    endfunction

    function automatic bit in_grid(input int r, input int c);
        return r < rows_used && c < cols_used;
    endfunction

    // A cell is solid when it is outside the grid, on its border, or blocked.
    function automatic bit cell_solid(input int r, input int c);
        if (!in_grid(r, c))
            return 1'b1;
        if (r == 0 || c == 0 || r == rows_used - 1 || c == cols_used - 1)
            return 1'b1;
        return occ_map[r][c];
    endfunction

    // Symmetric supercover walk from A toward B. The decision compares the
    // row and column progress on doubled half-cell centers: zero means the
    // line passes exactly through a corner and the walk steps diagonally.
    // The source cell is never tested; the destination always is.
    function automatic bit line_clear(input int ra, input int ca, input int rb, input int cb);
        int r;
        int c;
        int sr;
        int sc;
        int dr;
        int dc;
        int ix;
        int iy;
        int d;
        r  = ra;
        c  = ca;
        sr = (rb > ra) ? 1 : ((rb < ra) ? -1 : 0);
        sc = (cb > ca) ? 1 : ((cb < ca) ? -1 : 0);
        dr = (rb > ra) ? rb - ra : ra - rb;
        dc = (cb > ca) ? cb - ca : ca - cb;
        ix = 0;
        iy = 0;
        while (ix < dr || iy < dc)
        begin
            d = (1 + 2 * iy) * dr - (1 + 2 * ix) * dc;
            if (d == 0)
            begin
                r += sr;
                c += sc;
                ix++;
                iy++;
            end
            else if (d < 0)
            begin
                c += sc;
                iy++;
            end
            else
            begin
                r += sr;
                ix++;
            end
            if (r < 0 || c < 0)
                return 1'b0;
            if (cell_solid(r, c))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the answer to one accepted request and applies any cell write
    // to the shadow grid, so later queries see it in transfer order.
    function automatic sight_answer_t grid_response(input logic [1:0] op,
                                                    input logic [5:0] ra, input logic [5:0] ca,
                                                    input logic [5:0] rb, input logic [5:0] cb);
        sight_answer_t ans;
        ans = '{visible: 1'b0, status: 1'b0};
        case (op)
            OP_BLOCK, OP_FREE:
            begin
                if (in_grid(int'(ra), int'(ca)))
                    occ_map[ra][ca] = (op == OP_BLOCK);
                else
                    ans.status = 1'b1;
            end
            OP_SIGHT:
            begin
                if (in_grid(int'(ra), int'(ca)) && in_grid(int'(rb), int'(cb)))
                    ans.visible = line_clear(int'(ra), int'(ca), int'(rb), int'(cb));
                else
                    ans.status = 1'b1;
            end
            default:
            begin
                // The unused opcode changes nothing and answers all zeros.
            end
        endcase
        return ans;
    endfunction

    // Mostly a coordinate inside the current grid, sometimes anywhere in the
    // six-bit range so that out-of-grid items and every bit get exercised.
    function automatic int pick_coord(input int span);
        if ($urandom_range(99) < 12)
            return $urandom_range(63);
        return $urandom_range(span - 1);
    endfunction

    // A coordinate a few cells from base, for short queries that often see through.
    function automatic int near_coord(input int base);
        int v;
        v = base + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 63)
            v = 63;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Request side. The task is entered right after a rising edge, raises
    // valid with the payload and holds both until the transfer. It never
    // lowers valid between back-to-back requests; when a burst ends it may
    // drop valid for a random gap.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [5:0] ra, input logic [5:0] ca,
                             input logic [5:0] rb, input logic [5:0] cb);
        int gap;
        in_valid <= 1'b1;
        opcode   <= op;
        row_a    <= ra;
        col_a    <= ca;
        row_b    <= rb;
        col_b    <= cb;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_answers.push_back(grid_response(op, ra, ca, rb, cb));
        items_sent++;
        if (op == OP_SIGHT)
            queries_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 12);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Random request: mostly queries and cell writes, rarely the unused opcode.
    // Half of the queries aim close to the source so that many are visible.
    task automatic send_random_item();
        int pick;
        int ra;
        int ca;
        int rb;
        int cb;
        logic [1:0] op;
        pick = $urandom_range(99);
        if (pick < 45)
            op = OP_SIGHT;
        else if (pick < 72)
            op = OP_BLOCK;
        else if (pick < 97)
            op = OP_FREE;
        else
            op = OP_UNUSED;
        ra = pick_coord(rows_used);
        ca = pick_coord(cols_used);
        if ($urandom_range(1))
        begin
            rb = near_coord(ra);
            cb = near_coord(ca);
        end
        else
        begin
            rb = pick_coord(rows_used);
            cb = pick_coord(cols_used);
        end
        send_item(op, 6'(ra), 6'(ca), 6'(rb), 6'(cb));
    endtask

    // Stops offering requests and waits until every answer has come back.
    // Each request yields exactly one answer, so the core is idle after that.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both size registers while the core is idle.
    task automatic reshape(input logic [6:0] height, input logic [6:0] width);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= height;
        @(posedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        rows_used = clamp_size(height, GRID_MAX_ROWS);
        cols_used = clamp_size(width, GRID_MAX_COLS);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full 64 by 64 grid: trivial and long queries, border hits, a single
    // blocked cell seen from several directions, border writes and the
    // unused opcode with all-zero and all-one fields.
    task automatic test_directed_walks();
        send_item(OP_SIGHT,  6'd5,  6'd5,  6'd5,  6'd5);
        send_item(OP_SIGHT,  6'd1,  6'd1,  6'd62, 6'd62);
        send_item(OP_SIGHT,  6'd62, 6'd1,  6'd1,  6'd62);
        send_item(OP_SIGHT,  6'd1,  6'd1,  6'd0,  6'd0);
        send_item(OP_SIGHT,  6'd63, 6'd63, 6'd0,  6'd0);
        send_item(OP_SIGHT,  6'd63, 6'd0,  6'd62, 6'd1);
        send_item(OP_BLOCK,  6'd10, 6'd10, 6'd63, 6'd63);
        send_item(OP_SIGHT,  6'd10, 6'd2,  6'd10, 6'd30);
        send_item(OP_SIGHT,  6'd2,  6'd10, 6'd40, 6'd10);
        send_item(OP_SIGHT,  6'd10, 6'd10, 6'd10, 6'd30);
        send_item(OP_SIGHT,  6'd5,  6'd5,  6'd10, 6'd10);
        send_item(OP_SIGHT,  6'd9,  6'd9,  6'd11, 6'd11);
        send_item(OP_SIGHT,  6'd11, 6'd11, 6'd9,  6'd9);
        send_item(OP_FREE,   6'd10, 6'd10, 6'd0,  6'd0);
        send_item(OP_SIGHT,  6'd10, 6'd2,  6'd10, 6'd30);
        send_item(OP_BLOCK,  6'd0,  6'd0,  6'd0,  6'd0);
        send_item(OP_BLOCK,  6'd63, 6'd63, 6'd63, 6'd63);
        send_item(OP_SIGHT,  6'd1,  6'd20, 6'd60, 6'd22);
        send_item(OP_SIGHT,  6'd60, 6'd22, 6'd1,  6'd20);
        send_item(OP_UNUSED, 6'd63, 6'd63, 6'd63, 6'd63);
        send_item(OP_UNUSED, 6'd0,  6'd0,  6'd0,  6'd0);
        send_item(OP_FREE,   6'd0,  6'd0,  6'd0,  6'd0);
        send_item(OP_FREE,   6'd63, 6'd63, 6'd63, 6'd63);
    endtask

    // Register extremes and clamping, writes and queries outside the grid,
    // and a cell written while on the border that becomes interior later.
    task automatic test_grid_sizes();
        // Both registers below the minimum: a 3 by 3 grid with one free cell.
        reshape(7'd0, 7'd1);
        send_item(OP_SIGHT, 6'd1, 6'd1, 6'd1, 6'd1);
        send_item(OP_SIGHT, 6'd0, 6'd0, 6'd1, 6'd1);
        send_item(OP_SIGHT, 6'd1, 6'd1, 6'd2, 6'd2);
        send_item(OP_SIGHT, 6'd1, 6'd1, 6'd3, 6'd1);
        send_item(OP_SIGHT, 6'd5, 6'd0, 6'd1, 6'd1);
        send_item(OP_BLOCK, 6'd3, 6'd0, 6'd0, 6'd0);
        send_item(OP_BLOCK, 6'd0, 6'd3, 6'd0, 6'd0);
        send_item(OP_BLOCK, 6'd1, 6'd1, 6'd0, 6'd0);
        send_item(OP_SIGHT, 6'd0, 6'd1, 6'd1, 6'd1);
        send_item(OP_FREE,  6'd1, 6'd1, 6'd0, 6'd0);

        // Height above the maximum, width below the minimum: a tall corridor.
        reshape(7'd127, 7'd2);
        send_item(OP_SIGHT, 6'd1, 6'd1, 6'd62, 6'd1);
        send_item(OP_SIGHT, 6'd1, 6'd1, 6'd1,  6'd3);

        // Row 5 is the bottom wall here; the stored bit must survive until
        // the grid grows and the cell turns into an interior obstacle.
        reshape(7'd6, 7'd64);
        send_item(OP_BLOCK, 6'd5, 6'd20, 6'd0, 6'd0);
        send_item(OP_SIGHT, 6'd1, 6'd20, 6'd4, 6'd20);
        send_item(OP_SIGHT, 6'd1, 6'd20, 6'd5, 6'd20);
        send_item(OP_SIGHT, 6'd1, 6'd20, 6'd6, 6'd20);
        reshape(7'd64, 7'd64);
        send_item(OP_SIGHT, 6'd1, 6'd20, 6'd10, 6'd20);
        send_item(OP_FREE,  6'd5, 6'd20, 6'd0,  6'd0);
        send_item(OP_SIGHT, 6'd1, 6'd20, 6'd10, 6'd20);

        // Just above the maximum on the height and well above it on the width.
        reshape(7'd65, 7'd100);
        send_item(OP_SIGHT, 6'd62, 6'd62, 6'd1, 6'd1);
    endtask

    // Random traffic across a series of grid shapes, extremes included.
    task automatic test_random_shapes();
        int shape_rows [8] = '{64, 3, 12, 64, 33, 0, 100, 64};
        int shape_cols [8] = '{64, 3, 40, 3, 64, 127, 5, 64};
        for (int s = 0; s < 8; s++)
        begin
            reshape(7'(shape_rows[s]), 7'(shape_cols[s]));
            repeat (160) send_random_item();
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the core has to stall its input with an answer waiting.
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        hold_left   = 300;
        repeat (12) send_random_item();
        sender_gaps = 1'b1;
    endtask

    // Full rate on both sides: no sender gaps and no receiver stalls.
    task automatic test_full_rate();
        sender_gaps   = 1'b0;
        receiver_idle = 1'b0;
        repeat (150) send_random_item();
        drain();
        sender_gaps   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Answer side. The receiver alternates between modes of no, light and heavy
    // stalling on its own schedule; a hold-off or the full-rate test overrides it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!receiver_idle)
            out_stall <= 1'b0;
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode_left = $urandom_range(20, 80);
                case ($urandom_range(2))
                    0:       rx_pct = 0;
                    1:       rx_pct = 25;
                    default: rx_pct = 60;
                endcase
            end
            else
                rx_mode_left--;
            out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // Every answer transfer is compared with the oldest outstanding prediction.
    sight_answer_t head_answer;

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("answer transfer with no request outstanding");
                errors++;
            end
            else
            begin
                head_answer = pending_answers.pop_front();
                answers_checked++;
                if (head_answer.visible)
                    clear_seen++;
                if (head_answer.status)
                    rejects_seen++;
                if (visible !== head_answer.visible)
                begin
                    $error("visible: expected %0b, got %0b", head_answer.visible, visible);
                    errors++;
                end
                if (status !== head_answer.status)
                begin
                    $error("status: expected %0b, got %0b", head_answer.status, status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any transfer on either channel proves progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence. All inputs are known from time zero; reset is held at
    // the start and then released for good. The core clears its grid after
    // reset with its input stalled, which the first request simply waits out.
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_BLOCK;
        row_a     <= '0;
        col_a     <= '0;
        row_b     <= '0;
        col_b     <= '0;
        out_stall <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_walks();
        test_grid_sizes();
        test_random_shapes();
        test_output_backpressure();
        test_full_rate();

        drain();
        // Leave room for a stray extra answer to show up and be flagged.
        repeat (150) @(posedge clk);

        $display("Checked %0d answers for %0d requests, %0d of them sight queries",
                 answers_checked, items_sent, queries_sent);
        $display("(%0d clear, %0d rejected), on grids from 3 by 3 to 64 by 64,",
                 clear_seen, rejects_seen);
        $display("with a 300-cycle output hold-off and a full-rate stretch.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
